/* rtl/mmrr_pkg.sv */
package mmrr_pkg;

  localparam int ElemWidth    = 16;
  localparam int ProdWidth    = 36;
  localparam int IdxWidth     = 3;
  localparam int CfgWidth     = 4;
  localparam int CfgAddrWidth = 2;

  // configuration register indexes
  localparam logic [CfgAddrWidth-1:0] CfgDimension = 2'd0;
  localparam logic [CfgAddrWidth-1:0] CfgFirstRow  = 2'd1;
  localparam logic [CfgAddrWidth-1:0] CfgEndRow    = 2'd2;

  typedef struct packed {
    logic signed [ElemWidth-1:0] a_element;
    logic signed [ElemWidth-1:0] b_element;
  } in_item_t;

  typedef struct packed {
    logic signed [ProdWidth-1:0] product_value;
    logic [IdxWidth-1:0]         row_index;
    logic [IdxWidth-1:0]         col_index;
    logic                        last_result;
  } res_item_t;

  // travels with each issued read pair down the mac pipeline
  typedef struct packed {
    logic                first;
    logic                last;
    logic [IdxWidth-1:0] row;
    logic [IdxWidth-1:0] col;
    logic                band_last;
  } mac_tag_t;

endpackage

/* rtl/mmrr_datapath.sv */
module mmrr_datapath
  import mmrr_pkg::*;
#(
  parameter int MAX_DIM = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] wr_addr,
  input  in_item_t                  wr_data,
  input  logic                      issue,
  input  logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] rd_addr_a,
  input  logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] rd_addr_b,
  input  mac_tag_t                  tag_in,
  output logic                      advance,
  output logic                      out_valid,
  input  logic                      out_ready,
  output res_item_t                 out_data
);

  localparam int Cells = MAX_DIM * MAX_DIM;

  logic [ElemWidth-1:0] mem_a [Cells];
  logic [ElemWidth-1:0] mem_b [Cells];

  logic signed [ElemWidth-1:0]   a_q;
  logic signed [ElemWidth-1:0]   b_q;
  logic signed [2*ElemWidth-1:0] prod;
  logic signed [ProdWidth-1:0]   acc;
  logic signed [ProdWidth-1:0]   acc_next;
  logic                          v1;
  logic                          v2;
  mac_tag_t                      tag1;
  mac_tag_t                      tag2;

  // whole pipeline holds while a finished result waits at the output
  assign advance = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_a[wr_addr] <= wr_data.a_element;
    end
    if (advance) begin
      a_q <= mem_a[rd_addr_a];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_b[wr_addr] <= wr_data.b_element;
    end
    if (advance) begin
      b_q <= mem_b[rd_addr_b];
    end
  end

  always_comb begin
    if (tag2.first) begin
      acc_next = ProdWidth'(prod);
    end else begin
      acc_next = acc + ProdWidth'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1        <= issue;
      v2        <= v1;
      out_valid <= v2 && tag2.last;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tag1 <= tag_in;
      tag2 <= tag1;
      prod <= a_q * b_q;
      if (v2) begin
        acc <= acc_next;
      end
      if (v2 && tag2.last) begin
        out_data.product_value <= acc_next;
        out_data.row_index     <= tag2.row;
        out_data.col_index     <= tag2.col;
        out_data.last_result   <= tag2.band_last;
      end
    end
  end

endmodule

/* rtl/mmrr_ctrl.sv */
module mmrr_ctrl
  import mmrr_pkg::*;
#(
  parameter int MAX_DIM = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CfgAddrWidth-1:0] cfg_addr,
  input  logic [CfgWidth-1:0]     cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  output logic                    wr_en,
  output logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] wr_addr,
  input  logic                    advance,
  output logic                    issue,
  output logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] rd_addr_a,
  output logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] rd_addr_b,
  output mac_tag_t                tag
);

  localparam int Cells = MAX_DIM * MAX_DIM;
  localparam int AW    = (Cells > 1) ? $clog2(Cells) : 1;
  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int TW    = $clog2(Cells + 1);

  localparam logic StLoad    = 1'b0;
  localparam logic StCompute = 1'b1;

  logic                state;
  logic [CfgWidth-1:0] dimension;
  logic [CfgWidth-1:0] first_row;
  logic [CfgWidth-1:0] end_row;
  logic [TW-1:0]       load_counter;
  logic [DW-1:0]       row;
  logic [DW-1:0]       col;
  logic [DW-1:0]       step;
  logic [AW-1:0]       a_base;
  logic [AW-1:0]       a_addr;
  logic [AW-1:0]       b_addr;

  logic [DW-1:0] dim_eff;
  logic [DW-1:0] end_eff;
  logic          load_done;
  logic          band_empty;
  logic          step_last;
  logic          col_last;
  logic          row_last;

  always_comb begin
    if (dimension == '0) begin
      dim_eff = DW'(1);
    end else if (32'(dimension) > MAX_DIM) begin
      dim_eff = DW'(MAX_DIM);
    end else begin
      dim_eff = DW'(dimension);
    end
    if (32'(end_row) < 32'(dim_eff)) begin
      end_eff = DW'(end_row);
    end else begin
      end_eff = dim_eff;
    end
  end

  // a shrunken dimension mid-load completes at the next pair
  assign load_done  = (32'(load_counter) + 32'd1) >= (32'(dim_eff) * 32'(dim_eff));
  assign band_empty = 32'(first_row) >= 32'(end_eff);
  assign step_last  = (32'(step) + 32'd1) == 32'(dim_eff);
  assign col_last   = (32'(col) + 32'd1) == 32'(dim_eff);
  assign row_last   = (32'(row) + 32'd1) == 32'(end_eff);

  assign in_ready  = (state == StLoad);
  assign wr_en     = in_valid && in_ready;
  assign wr_addr   = load_counter[AW-1:0];
  assign issue     = (state == StCompute);
  assign rd_addr_a = a_addr;
  assign rd_addr_b = b_addr;

  always_comb begin
    tag.first     = (step == '0);
    tag.last      = step_last;
    tag.row       = IdxWidth'(row);
    tag.col       = IdxWidth'(col);
    tag.band_last = row_last && col_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dimension <= CfgWidth'(8);
      first_row <= '0;
      end_row   <= CfgWidth'(8);
    end else if (cfg_we) begin
      case (cfg_addr)
        CfgDimension: dimension <= cfg_wdata;
        CfgFirstRow:  first_row <= cfg_wdata;
        CfgEndRow:    end_row   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= StLoad;
      load_counter <= '0;
      row          <= '0;
      col          <= '0;
      step         <= '0;
      a_base       <= '0;
      a_addr       <= '0;
      b_addr       <= '0;
    end else begin
      case (state)
        StLoad: begin
          if (wr_en) begin
            if (load_done) begin
              load_counter <= '0;
              if (!band_empty) begin
                state  <= StCompute;
                row    <= DW'(first_row);
                col    <= '0;
                step   <= '0;
                a_base <= AW'(32'(first_row) * 32'(dim_eff));
                a_addr <= AW'(32'(first_row) * 32'(dim_eff));
                b_addr <= '0;
              end
            end else begin
              load_counter <= TW'(32'(load_counter) + 32'd1);
            end
          end
        end
        StCompute: begin
          if (advance) begin
            if (step_last) begin
              step <= '0;
              if (col_last) begin
                // next row of a
                col    <= '0;
                b_addr <= '0;
                row    <= DW'(32'(row) + 32'd1);
                a_base <= AW'(32'(a_base) + 32'(dim_eff));
                a_addr <= AW'(32'(a_base) + 32'(dim_eff));
                if (row_last) begin
                  state <= StLoad;
                end
              end else begin
                col    <= DW'(32'(col) + 32'd1);
                b_addr <= AW'(32'(col) + 32'd1);
                a_addr <= a_base;
              end
            end else begin
              step   <= DW'(32'(step) + 32'd1);
              a_addr <= AW'(32'(a_addr) + 32'd1);
              b_addr <= AW'(32'(b_addr) + 32'(dim_eff));
            end
          end
        end
        default: state <= StLoad;
      endcase
    end
  end

endmodule

/* rtl/matrix_multiply_row_range.sv */
// Loads d*d pairs (a_element, b_element) of two square matrices, one per cycle in row-major
// order, then computes every element of rows first_row..min(end_row,d)-1 of C = A*B on a
// single multiply-accumulate unit fed by one read port per element store; the pipeline
// stalls while a result waits at the output. No input is taken while a band is computed;
// loading of the next pair of matrices starts once the last read has been issued, while
// the final results are still draining.
module matrix_multiply_row_range
  import mmrr_pkg::*;
#(
  parameter int MAX_DIM = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CfgAddrWidth-1:0] cfg_addr,
  input  logic [CfgWidth-1:0]     cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  in_item_t                in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output res_item_t               out_data
);

  localparam int Cells = MAX_DIM * MAX_DIM;
  localparam int AW    = (Cells > 1) ? $clog2(Cells) : 1;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          advance;
  logic          issue;
  logic [AW-1:0] rd_addr_a;
  logic [AW-1:0] rd_addr_b;
  mac_tag_t      tag;

  mmrr_ctrl #(
    .MAX_DIM(MAX_DIM)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .advance  (advance),
    .issue    (issue),
    .rd_addr_a(rd_addr_a),
    .rd_addr_b(rd_addr_b),
    .tag      (tag)
  );

  mmrr_datapath #(
    .MAX_DIM(MAX_DIM)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (in_data),
    .issue    (issue),
    .rd_addr_a(rd_addr_a),
    .rd_addr_b(rd_addr_b),
    .tag_in   (tag),
    .advance  (advance),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

`ifndef SYNTHESIS
  // loading and computing never overlap
  assert property (@(posedge clk) disable iff (rst) !(in_ready && issue))
    else $error("load and mac issue at the same time");

  // a band starts right after the transaction that completes a load
  assert property (@(posedge clk) disable iff (rst) $rose(issue) |-> $past(wr_en))
    else $error("band started without a completing load");

  // a band starts on the first step of column zero
  assert property (@(posedge clk) disable iff (rst)
    $rose(issue) |-> (tag.first && tag.col == '0))
    else $error("band started mid dot product");
`endif

endmodule
